// ----- sv/wse_pkg.sv -----
// ----------------------------------------------------------------------------
// Wheel speed estimator package
// Shared widths, codes, register defaults and the divider status struct.
// ----------------------------------------------------------------------------
package wse_pkg;

    // request opcodes
    localparam logic OP_UPDATE  = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNTS_REV = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CIRCUM     = 2'd3;

    localparam int CFG_W = 16;
    localparam logic [CFG_W-1:0] MIN_WINDOW_RST = 16'd20;
    localparam logic [CFG_W-1:0] TIMEOUT_RST    = 16'd200;
    localparam logic [CFG_W-1:0] COUNTS_REV_RST = 16'd360;
    localparam logic [CFG_W-1:0] CIRCUM_RST     = 16'd5632;

    // divider geometry: numerator < den * 2^QUOT_W is required on start
    localparam int QUOT_W = 32;
    localparam int DEN_W  = 48;
    localparam int NUM_W  = 58;
    localparam int CNT_W  = $clog2(QUOT_W);

    // shared multiplier operand widths
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 32;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // 1000 ms/s scaled to Q16.16
    localparam logic [MUL_B_W-1:0] RPS_SCALE = 32'd65536000;

    // divide by 5: (x * 0xCCCCCCCD) >> 34 is exact for any 32-bit x
    localparam logic [MUL_B_W-1:0] DIV5_RECIP = 32'hCCCC_CCCD;
    localparam int                 DIV5_SHIFT = 34;
    // floor(x / 5) for x = 2^32 and 2^32 + 1, the only 33-bit operands
    localparam logic [QUOT_W-1:0]  DIV5_TOP   = 32'd858993459;

    typedef struct packed {
        logic busy;
        logic done;
    } wse_div_stat_t;

endpackage

// ----- sv/wse_div.sv -----
// ----------------------------------------------------------------------------
// Restoring divider
// Radix-2, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wse_div import wse_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [NUM_W-1:0]    num,
    input  logic [DEN_W-1:0]    den,
    output logic [QUOT_W-1:0]   quot,
    output wse_div_stat_t       stat
);

    logic [DEN_W-1:0]   rem_reg;
    logic [DEN_W-1:0]   rem_next;
    logic [QUOT_W-1:0]  shf_reg;
    logic [QUOT_W-1:0]  shf_next;
    logic [DEN_W-1:0]   den_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [DEN_W:0]     trial;
    logic [DEN_W:0]     trial_sub;
    logic               ge;

    // shift next numerator bit into the partial remainder, try a subtract
    always_comb
    begin
        trial     = {rem_reg, shf_reg[QUOT_W-1]};
        trial_sub = trial - {1'b0, den_reg};
        ge        = trial >= {1'b0, den_reg};
        rem_next  = ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
        shf_next  = {shf_reg[QUOT_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            shf_reg  <= '0;
            den_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rem_reg  <= DEN_W'(num[NUM_W-1:QUOT_W]);
                shf_reg  <= num[QUOT_W-1:0];
                den_reg  <= den;
                cnt_reg  <= CNT_W'(QUOT_W - 1);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg <= rem_next;
                shf_reg <= shf_next;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    assign quot      = shf_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ----- sv/wheel_speed_estimator.sv -----
// ----------------------------------------------------------------------------
// Wheel speed estimator
// Windowed encoder speed with a 1/5-weight exponential filter, fixed point.
// ----------------------------------------------------------------------------
// One request in, one result out. A request is taken only while the block is
// idle; a finished result may still wait in the output register meanwhile.
// A restart, a request without encoder movement, or a tick that does not
// close a speed window goes from the update step to the cm/s product and on
// to the output register. A tick that closes a window (window nonzero and
// at least min_window_ms long, nonzero counts per revolution) makes one pass
// through the radix-2 divider for the instant speed plus four products on
// the shared 32x32 multiplier (denominator, scaled counts, reciprocal divide
// by 5 of the filter step, cm/s). When the instant speed is known to saturate
// the divider is skipped. A result still waiting in the output register holds
// the sequencer in its last state until taken. Results are Q16.16 rev/s and
// cm/s rounded half away from zero, saturated. Configuration is written
// through cfg_we/cfg_index/cfg_data; the user must write it only while idle,
// and the block itself does not enforce this.
// ----------------------------------------------------------------------------
module wheel_speed_estimator import wse_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]        cfg_data,

    input  logic                    req_valid,
    output logic                    req_ready,
    input  logic                    operation,
    input  logic signed [31:0]      encoder_count,
    input  logic [31:0]             time_ms,

    output logic                    rsp_valid,
    input  logic                    rsp_ready,
    output logic signed [31:0]      total_count,
    output logic signed [31:0]      speed_rps_q16,
    output logic signed [15:0]      speed_cms
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_UPD,       // delta, window bookkeeping, timeout
        S_MULD,      // den = counts per revolution * window ms
        S_MULM,      // |window counts| * 65536000
        S_NUM,       // add den/2 for rounding
        S_CHK,       // quotient overflow check
        S_DIV_GO,
        S_DIV_WAIT,
        S_INST,      // saturate instant speed, diff against filter
        S_FNUM,      // (|diff| + 2) / 5 by reciprocal multiply
        S_FADD,      // filter update
        S_CMSM,      // |filtered| * circumference
        S_OUT
    } state_t;

    state_t state_reg;

    // configuration
    logic [CFG_W-1:0] min_window_reg;
    logic [CFG_W-1:0] timeout_reg;
    logic [CFG_W-1:0] counts_rev_reg;
    logic [CFG_W-1:0] circum_reg;

    // captured request
    logic        op_reg;
    logic [31:0] cur_reg;
    logic [31:0] now_reg;

    // estimator state
    logic [31:0] prev_reg;
    logic [31:0] total_reg;
    logic [31:0] wc_reg;
    logic [31:0] filt_reg;
    logic [31:0] wstart_reg;
    logic [31:0] last_reg;

    // datapath scratch
    logic [31:0]        dt_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [MUL_P_W-1:0] prod_reg;
    logic [NUM_W-1:0]   num_reg;
    logic [QUOT_W-1:0]  q_reg;
    logic [32:0]        diff_reg;

    // result register
    logic        rsp_valid_reg;
    logic [31:0] rsp_total_reg;
    logic [31:0] rsp_speed_reg;
    logic [15:0] rsp_cms_reg;

    // combinational
    logic signed [32:0] delta;
    logic [15:0]        d16;
    logic [31:0]        d32;
    logic [31:0]        wc_add;
    logic [31:0]        dt_now;
    logic               close_ok;
    logic               timeout_hit;
    logic [31:0]        wc_abs;
    logic [31:0]        filt_abs;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] mul_p;
    logic [31:0]        inst;
    logic [32:0]        diff_next;
    logic [32:0]        diff_abs;
    logic [32:0]        filt_num;
    logic [46:0]        cms_mag;
    logic [22:0]        cms_r;
    logic [15:0]        cms_next;
    logic               div_start;
    logic [QUOT_W-1:0]  div_quot;
    wse_div_stat_t      div_stat;

    // ---- update decode: clamped delta, window and timeout tests ----
    always_comb
    begin
        delta = $signed({cur_reg[31], cur_reg}) - $signed({prev_reg[31], prev_reg});
        if (delta > 33'sd32767)
            d16 = 16'h7FFF;
        else if (delta < -33'sd32768)
            d16 = 16'h8000;
        else
            d16 = delta[15:0];
        d32         = {{16{d16[15]}}, d16};
        wc_add      = wc_reg + d32;
        dt_now      = now_reg - wstart_reg;
        // zero window length or zero counts per revolution keeps the window open
        close_ok    = (dt_now >= {16'd0, min_window_reg}) && (dt_now != '0)
                      && (counts_rev_reg != '0);
        timeout_hit = (last_reg != '0) && ((now_reg - last_reg) > {16'd0, timeout_reg});
    end

    // ---- shared multiplier ----
    always_comb
    begin
        wc_abs   = wc_reg[31] ? (~wc_reg + 32'd1) : wc_reg;
        filt_abs = filt_reg[31] ? (~filt_reg + 32'd1) : filt_reg;
        case (state_reg)
            S_MULD:
            begin
                mul_a = dt_reg;
                mul_b = MUL_B_W'(counts_rev_reg);
            end
            S_MULM:
            begin
                mul_a = wc_abs;
                mul_b = RPS_SCALE;
            end
            S_FNUM:
            begin
                mul_a = filt_num[31:0];
                mul_b = DIV5_RECIP;
            end
            default:
            begin
                mul_a = filt_abs;
                mul_b = MUL_B_W'(circum_reg);
            end
        endcase
        mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
    end

    // ---- instant speed saturation, filter difference ----
    always_comb
    begin
        if (!wc_reg[31])
            inst = q_reg[31] ? 32'h7FFF_FFFF : q_reg;
        else
            inst = (q_reg > 32'h8000_0000) ? 32'h8000_0000 : (~q_reg + 32'd1);
        diff_next = {inst[31], inst} - {filt_reg[31], filt_reg};
        diff_abs  = diff_reg[32] ? (~diff_reg + 33'd1) : diff_reg;
        // at most 2^32 + 1
        filt_num  = diff_abs + 33'd2;
    end

    // ---- cm/s: (|speed * circ| + 2^23) >> 24, saturate to int16 ----
    always_comb
    begin
        cms_mag = prod_reg[46:0] + 47'h80_0000;
        cms_r   = cms_mag[46:24];
        if (!filt_reg[31])
            cms_next = (cms_r > 23'd32767) ? 16'h7FFF : cms_r[15:0];
        else
            cms_next = (cms_r > 23'd32768) ? 16'h8000 : (~cms_r[15:0] + 16'd1);
    end

    assign div_start = (state_reg == S_DIV_GO);

    wse_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_reg),
        .den   (den_reg),
        .quot  (div_quot),
        .stat  (div_stat)
    );

    // ---- configuration registers ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_window_reg <= MIN_WINDOW_RST;
            timeout_reg    <= TIMEOUT_RST;
            counts_rev_reg <= COUNTS_REV_RST;
            circum_reg     <= CIRCUM_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MIN_WINDOW: min_window_reg <= cfg_data;
                CFG_TIMEOUT:    timeout_reg    <= cfg_data;
                CFG_COUNTS_REV: counts_rev_reg <= cfg_data;
                CFG_CIRCUM:     circum_reg     <= cfg_data;
                default:        ;
            endcase
        end
    end

    // ---- sequencer ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_UPDATE;
            cur_reg       <= '0;
            now_reg       <= '0;
            prev_reg      <= '0;
            total_reg     <= '0;
            wc_reg        <= '0;
            filt_reg      <= '0;
            wstart_reg    <= '0;
            last_reg      <= '0;
            dt_reg        <= '0;
            den_reg       <= '0;
            prod_reg      <= '0;
            num_reg       <= '0;
            q_reg         <= '0;
            diff_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_total_reg <= '0;
            rsp_speed_reg <= '0;
            rsp_cms_reg   <= '0;
        end
        else
        begin
            // in S_OUT a taken result is replaced by the new one below
            if (rsp_valid_reg && rsp_ready && (state_reg != S_OUT))
                rsp_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        op_reg    <= operation;
                        cur_reg   <= encoder_count;
                        now_reg   <= time_ms;
                        state_reg <= S_UPD;
                    end
                end

                S_UPD:
                begin
                    state_reg <= S_CMSM;
                    if (op_reg == OP_RESTART)
                    begin
                        prev_reg   <= cur_reg;
                        total_reg  <= '0;
                        wc_reg     <= '0;
                        filt_reg   <= '0;
                        wstart_reg <= '0;
                        last_reg   <= '0;
                    end
                    else if (d16 != '0)
                    begin
                        // a tick refreshes last_reg to now, so no timeout here
                        total_reg <= total_reg + d32;
                        prev_reg  <= cur_reg;
                        last_reg  <= now_reg;
                        if (wstart_reg == '0)
                        begin
                            wc_reg     <= '0;
                            wstart_reg <= now_reg;
                        end
                        else
                        begin
                            wc_reg <= wc_add;
                            if (close_ok)
                            begin
                                wstart_reg <= now_reg;
                                dt_reg     <= dt_now;
                                state_reg  <= S_MULD;
                            end
                        end
                    end
                    else if (timeout_hit)
                    begin
                        filt_reg   <= '0;
                        wc_reg     <= '0;
                        wstart_reg <= '0;
                    end
                end

                S_MULD:
                begin
                    den_reg   <= mul_p[DEN_W-1:0];
                    state_reg <= S_MULM;
                end

                S_MULM:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= S_NUM;
                end

                S_NUM:
                begin
                    num_reg   <= prod_reg[NUM_W-1:0] + NUM_W'(den_reg[DEN_W-1:1]);
                    state_reg <= S_CHK;
                end

                S_CHK:
                begin
                    // quotient would need more than 32 bits: saturates anyway
                    if (DEN_W'(num_reg[NUM_W-1:QUOT_W]) >= den_reg)
                    begin
                        q_reg     <= '1;
                        state_reg <= S_INST;
                    end
                    else
                    begin
                        state_reg <= S_DIV_GO;
                    end
                end

                S_DIV_GO:
                begin
                    state_reg <= S_DIV_WAIT;
                end

                S_DIV_WAIT:
                begin
                    if (div_stat.done)
                    begin
                        q_reg     <= div_quot;
                        state_reg <= S_INST;
                    end
                end

                S_INST:
                begin
                    diff_reg  <= diff_next;
                    state_reg <= S_FNUM;
                end

                S_FNUM:
                begin
                    q_reg     <= filt_num[32] ? DIV5_TOP
                                              : QUOT_W'(mul_p[MUL_P_W-1:DIV5_SHIFT]);
                    state_reg <= S_FADD;
                end

                S_FADD:
                begin
                    filt_reg  <= diff_reg[32] ? (filt_reg - q_reg) : (filt_reg + q_reg);
                    wc_reg    <= '0;
                    state_reg <= S_CMSM;
                end

                S_CMSM:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= S_OUT;
                end

                S_OUT:
                begin
                    if (!rsp_valid_reg || rsp_ready)
                    begin
                        rsp_valid_reg <= 1'b1;
                        rsp_total_reg <= total_reg;
                        rsp_speed_reg <= filt_reg;
                        rsp_cms_reg   <= cms_next;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign req_ready     = (state_reg == S_IDLE);
    assign rsp_valid     = rsp_valid_reg;
    assign total_count   = signed'(rsp_total_reg);
    assign speed_rps_q16 = signed'(rsp_speed_reg);
    assign speed_cms     = signed'(rsp_cms_reg);

`ifndef SYNTHESIS
    // divider runs only while the sequencer waits for it
    a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> state_reg == S_DIV_WAIT)
        else $error("divider busy outside S_DIV_WAIT");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> state_reg == S_DIV_WAIT)
        else $error("divider done outside S_DIV_WAIT");

    // an unopened window holds no counts between requests
    a_window_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && wstart_reg == '0) |-> wc_reg == '0)
        else $error("window counts without window start");

    // filter state moves only while a request is being worked
    a_filt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |=> $stable(filt_reg))
        else $error("filtered speed changed while idle");
`endif

endmodule
